// File: sv/rcm_pkg.sv
`default_nettype none

package rcm_pkg;

	// action codes on the result
	typedef enum logic [2:0] {
		ACT_STOP  = 3'd0,
		ACT_RIGHT = 3'd1,
		ACT_LEFT  = 3'd2,
		ACT_FWD   = 3'd3,
		ACT_BACK  = 3'd4,
		ACT_NONE  = 3'd5
	} action_t;

	// pulse limits in microseconds
	localparam logic [11:0] PULSE_MIN = 12'd600;
	localparam logic [11:0] PULSE_MAX = 12'd1600;
	localparam logic [10:0] PULSE_MID = 11'd1100;

	// full scale of a mixed power, units of 0.008 percent
	localparam logic signed [15:0] FULL_SCALE = 16'sd12500;

	// floor(n / 3125) as (n * DUTY_RECIP) >> DUTY_SHIFT, exact for n below 15.2e6
	localparam logic [23:0] DUTY_RECIP = 24'd10995117;
	localparam int          DUTY_SHIFT = 35;

	// whole percent from a distance to center: floor(x / 5) as (x * 205) >> 10
	localparam logic [7:0] DIV5_RECIP = 8'd205;

	// result of the mixing stage
	typedef struct packed {
		action_t            action;
		logic               right_reverse;
		logic               left_reverse;
		logic signed [15:0] right_pow;
		logic signed [15:0] left_pow;
	} mix_t;

	// saturate a pulse to 600..1600
	function automatic logic [10:0] pulse_clamp(input logic [11:0] p);
		logic [11:0] v;
		begin
			if (p > PULSE_MAX) begin
				v = PULSE_MAX;
			end else if (p < PULSE_MIN) begin
				v = PULSE_MIN;
			end else begin
				v = p;
			end
			pulse_clamp = v[10:0];
		end
	endfunction

	// map clamped pulse to -2500..2500 (units of 0.04 percent)
	function automatic logic signed [13:0] pulse_units(input logic [10:0] p);
		logic [10:0] x;
		logic [12:0] x5;
		begin
			x = p - PULSE_MIN[10:0];
			x5 = {2'b0, x} + {x, 2'b0};
			pulse_units = $signed({1'b0, x5}) - 14'sd2500;
		end
	endfunction

	// magnitude in whole percent, truncated
	function automatic logic [6:0] pulse_whole(input logic [10:0] p);
		logic [10:0] diff;
		logic [16:0] prod;
		begin
			diff = (p >= PULSE_MID) ? (p - PULSE_MID) : (PULSE_MID - p);
			prod = {8'b0, diff[8:0]} * {9'b0, DIV5_RECIP};
			pulse_whole = prod[16:10];
		end
	endfunction

endpackage

`default_nettype wire

// File: sv/rcm_mix.sv
`default_nettype none

module rcm_mix import rcm_pkg::*; (
	input  logic [11:0] steer_pulse,
	input  logic [11:0] throttle_pulse,
	input  logic [6:0]  deadband_percent,
	output mix_t        mix
);

	logic [10:0]        ps;
	logic [10:0]        pt;
	logic signed [13:0] s;
	logic signed [13:0] t;
	logic [12:0]        d_u;
	logic signed [13:0] d;
	logic               t_in;
	logic               s_in;
	logic [13:0]        turn_pow;
	logic [13:0]        back_base;
	logic signed [15:0] s16;
	logic signed [15:0] t5;

	// pulses to signed units
	assign ps = pulse_clamp(steer_pulse);
	assign pt = pulse_clamp(throttle_pulse);
	assign s  = pulse_units(ps);
	assign t  = pulse_units(pt);

	// deadband in units and window tests
	assign d_u  = {6'b0, deadband_percent} * 13'd25;
	assign d    = $signed({1'b0, d_u});
	assign t_in = (t < d) && (t > -d);
	assign s_in = (s < d) && (s > -d);

	// whole-percent powers scaled back to mixing units
	assign turn_pow  = {7'b0, pulse_whole(ps)} * 14'd125;
	assign back_base = {7'b0, pulse_whole(pt)} * 14'd125;

	assign s16 = 16'(s);
	assign t5  = (16'(t) <<< 2) + 16'(t);

	// decide action, directions and side powers
	always_comb begin
		mix = '0;
		mix.action = ACT_NONE;
		if (t_in && s_in) begin
			mix.action = ACT_STOP;
		end else if (t_in) begin
			if (s > d) begin
				mix.action        = ACT_RIGHT;
				mix.left_reverse  = 1'b1;
				mix.right_pow     = $signed({2'b0, turn_pow});
				mix.left_pow      = $signed({2'b0, turn_pow});
			end else if (s < -d) begin
				mix.action        = ACT_LEFT;
				mix.right_reverse = 1'b1;
				mix.right_pow     = $signed({2'b0, turn_pow});
				mix.left_pow      = $signed({2'b0, turn_pow});
			end
		end else if (t > 14'sd0) begin
			mix.action        = ACT_FWD;
			mix.right_reverse = 1'b1;
			mix.left_reverse  = 1'b1;
			mix.right_pow     = t5 - s16;
			mix.left_pow      = t5 + s16;
		end else if (t < 14'sd0) begin
			mix.action    = ACT_BACK;
			mix.right_pow = $signed({2'b0, back_base}) - s16;
			mix.left_pow  = $signed({2'b0, back_base}) + s16;
		end
	end

endmodule

`default_nettype wire

// File: sv/rcm_duty.sv
`default_nettype none

module rcm_duty import rcm_pkg::*; (
	input  logic signed [15:0] power,
	output logic [11:0]        duty
);

	logic [13:0] c;
	logic [25:0] m;
	logic [23:0] m4;
	logic [47:0] prod;

	// clamp to 0..full scale
	always_comb begin
		if (power < 16'sd0) begin
			c = '0;
		end else if (power > FULL_SCALE) begin
			c = FULL_SCALE[13:0];
		end else begin
			c = power[13:0];
		end
	end

	// round(c * 4095 / 12500), ties up: floor((c*4095 + 6250) / 12500)
	assign m    = {c, 12'b0} - {12'b0, c} + 26'd6250;
	assign m4   = m[25:2];
	assign prod = {24'b0, m4} * {24'b0, DUTY_RECIP};
	assign duty = prod[DUTY_SHIFT+11:DUTY_SHIFT];

endmodule

`default_nettype wire

// File: sv/rc_pulse_to_tank_drive_mixer.sv
`default_nettype none

// Tank-drive mixer for two radio-control channels. Each transfer on the input
// carries a steering and a throttle pulse width in microseconds; each produces
// exactly one result transfer with an action code, a direction bit per motor
// and a 12-bit PWM off count per motor. The block is a three-stage pipeline
// (input register, mixing register, output register) and accepts one item per
// cycle while the output is not stalled. An item passes from the input register
// through the mixing register to the output register, which drives out_valid.
// The throughput is one item per cycle while out_ready stays high: each stage
// loads whenever it is empty or its content moves on, and the ready chain runs
// back through the stages without a gap. deadband_percent resets to 5
// and is written through cfg_wr_en/cfg_wr_data; write it only while the
// pipeline is empty.
module rc_pulse_to_tank_drive_mixer import rcm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [6:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [11:0] steer_pulse,
	input  logic [11:0] throttle_pulse,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  action,
	output logic        right_reverse,
	output logic        left_reverse,
	output logic [11:0] right_duty,
	output logic [11:0] left_duty
);

	logic [6:0]  deadband_q;
	logic        v_s1;
	logic        v_s2;
	logic        v_s3;
	logic        adv_s1;
	logic        adv_s2;
	logic        adv_s3;
	logic [11:0] steer_s1;
	logic [11:0] throttle_s1;
	mix_t        mix_comb;
	mix_t        mix_s2;
	logic [11:0] rduty_comb;
	logic [11:0] lduty_comb;
	action_t     action_s3;
	logic        rrev_s3;
	logic        lrev_s3;
	logic [11:0] rduty_s3;
	logic [11:0] lduty_s3;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= 7'd5;
		end else if (cfg_wr_en) begin
			deadband_q <= cfg_wr_data;
		end
	end

	// stage advance: a stage loads when it is empty or its content moves on
	assign adv_s3   = !v_s3 || out_ready;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= in_valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
			if (adv_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			steer_s1    <= steer_pulse;
			throttle_s1 <= throttle_pulse;
		end
	end

	rcm_mix u_mix (
		.steer_pulse      (steer_s1),
		.throttle_pulse   (throttle_s1),
		.deadband_percent (deadband_q),
		.mix              (mix_comb)
	);

	// mixing register
	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			mix_s2 <= mix_comb;
		end
	end

	rcm_duty u_duty_right (
		.power (mix_s2.right_pow),
		.duty  (rduty_comb)
	);

	rcm_duty u_duty_left (
		.power (mix_s2.left_pow),
		.duty  (lduty_comb)
	);

	// output register
	always_ff @(posedge clk) begin
		if (adv_s3 && v_s2) begin
			action_s3 <= mix_s2.action;
			rrev_s3   <= mix_s2.right_reverse;
			lrev_s3   <= mix_s2.left_reverse;
			rduty_s3  <= rduty_comb;
			lduty_s3  <= lduty_comb;
		end
	end

	assign out_valid     = v_s3;
	assign action        = action_s3;
	assign right_reverse = rrev_s3;
	assign left_reverse  = lrev_s3;
	assign right_duty    = rduty_s3;
	assign left_duty     = lduty_s3;

endmodule

`default_nettype wire
